// File: sv/rigid_transform_closest_point_macros.svh
// Assertion macros of the closest-point search RTL, used by rtcp_ctrl.
`ifndef RIGID_TRANSFORM_CLOSEST_POINT_MACROS_SVH
`define RIGID_TRANSFORM_CLOSEST_POINT_MACROS_SVH

// same-cycle implication, disabled during reset
`define RTCP_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rtcp assertion failed (same cycle)");

// next-cycle implication, disabled during reset
`define RTCP_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rtcp assertion failed (next cycle)");

`endif

// File: sv/rtcp_pkg.sv
// Types, codes and helpers of the rigid-transform closest-point search.
package rtcp_pkg;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   localparam logic [2:0] CSR_ROT_ROW0    = 3'd0;
   localparam logic [2:0] CSR_ROT_ROW1    = 3'd1;
   localparam logic [2:0] CSR_ROT_ROW2    = 3'd2;
   localparam logic [2:0] CSR_TRANSLATION = 3'd3;
   localparam logic [2:0] CSR_POINT_COUNT = 3'd4;

   localparam logic [47:0] ROT_ROW0_RESET = 48'h0000_0000_4000;
   localparam logic [47:0] ROT_ROW1_RESET = 48'h0000_4000_0000;
   localparam logic [47:0] ROT_ROW2_RESET = 48'h4000_0000_0000;
   localparam logic [10:0] COUNT_RESET    = 11'd1;

   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] MUL_STEPS   = 4'd9;
   localparam logic [STEP_W-1:0] XFORM_STEPS = 4'd11;
   localparam logic [STEP_W-1:0] SCAN_LAT    = 4'd4;

   typedef struct packed {
      logic               action;
      logic [9:0]         slot;
      logic signed [19:0] point_x;
      logic signed [19:0] point_y;
      logic signed [19:0] point_z;
   } req_type;

   typedef struct packed {
      logic [9:0]         match_index;
      logic signed [19:0] match_x;
      logic signed [19:0] match_y;
      logic signed [19:0] match_z;
      logic [45:0]        min_distance;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_XFORM,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic       load_we;
      logic       capture;
      logic       mul_issue;
      logic [1:0] mul_row;
      logic [1:0] mul_col;
      logic       scan_issue;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic out_busy;
   } sts_type;

   function automatic logic [1:0] step_row(input logic [STEP_W-1:0] step);
      logic [1:0] r;
      unique case (step)
         4'd0, 4'd1, 4'd2: r = 2'd0;
         4'd3, 4'd4, 4'd5: r = 2'd1;
         4'd6, 4'd7, 4'd8: r = 2'd2;
         default:          r = 2'd0;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] step_col(input logic [STEP_W-1:0] step);
      logic [1:0] c;
      unique case (step)
         4'd0, 4'd3, 4'd6: c = 2'd0;
         4'd1, 4'd4, 4'd7: c = 2'd1;
         4'd2, 4'd5, 4'd8: c = 2'd2;
         default:          c = 2'd0;
      endcase
      return c;
   endfunction

   function automatic logic signed [19:0] sat20(input logic signed [25:0] v);
      logic signed [19:0] r;
      if (v > 26'sd524287) begin
         r = 20'sd524287;
      end else if (v < -26'sd524288) begin
         r = -20'sd524288;
      end else begin
         r = v[19:0];
      end
      return r;
   endfunction

endpackage

// File: sv/rtcp_ctrl.sv
// Sequencer: accepts beats, steps the transform, scan and result hand-off.
`include "rigid_transform_closest_point_macros.svh"

module rtcp_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_action,
   output logic             req_stall,
   output rtcp_pkg::cmd_type cmd,
   input  rtcp_pkg::sts_type sts
);
   import rtcp_pkg::*;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (req_valid && req_action == ACT_QUERY) begin
               state_in = ST_XFORM;
            end
         end
         ST_XFORM: begin
            if (step_ff == XFORM_STEPS - 4'd1) begin
               state_in = ST_SCAN;
               step_in  = '0;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         ST_SCAN: begin
            step_in = '0;
            if (sts.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (step_ff == SCAN_LAT - 4'd1) begin
               state_in = ST_DONE;
               step_in  = '0;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         ST_DONE: begin
            if (!sts.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            step_in  = '0;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_we = (req_action == ACT_LOAD);
               cmd.capture = (req_action == ACT_QUERY);
            end
         end
         ST_XFORM: begin
            cmd.mul_issue = (step_ff < MUL_STEPS);
            cmd.mul_row   = step_row(step_ff);
            cmd.mul_col   = step_col(step_ff);
         end
         ST_SCAN: begin
            cmd.scan_issue = 1'b1;
         end
         ST_DRAIN: begin
         end
         ST_DONE: begin
            cmd.out_load = !sts.out_busy;
         end
         default: begin
         end
      endcase
   end

   `RTCP_ASSERT_IMPL(a_load_free, clock, reset, cmd.out_load, !sts.out_busy)
   `RTCP_ASSERT_NEXT(a_query_xform, clock, reset,
      req_valid && !req_stall && req_action == ACT_QUERY, state_ff == ST_XFORM)
   `RTCP_ASSERT_NEXT(a_load_idle, clock, reset,
      req_valid && !req_stall && req_action == ACT_LOAD, state_ff == ST_IDLE)
   `RTCP_ASSERT_NEXT(a_drain_done, clock, reset,
      state_ff == ST_DRAIN && step_ff == SCAN_LAT - 4'd1, state_ff == ST_DONE)

endmodule

// File: sv/rtcp_dp.sv
// Datapath: registers, point store, transform, distance pipeline, result register.
module rtcp_dp #(
   parameter int MAX_POINTS = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  rtcp_pkg::req_type req_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [59:0]       csr_wdata,
   input  rtcp_pkg::cmd_type cmd,
   output rtcp_pkg::sts_type sts,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rtcp_pkg::rsp_type rsp_data
);
   import rtcp_pkg::*;

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int LW = (CW > 11) ? CW : 11;
   localparam int SW = (AW > 10) ? AW : 10;

   // configuration
   logic [47:0] rot_ff [3];
   logic [59:0] trans_ff;
   logic [10:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff[0] <= ROT_ROW0_RESET;
         rot_ff[1] <= ROT_ROW1_RESET;
         rot_ff[2] <= ROT_ROW2_RESET;
         trans_ff  <= '0;
         count_ff  <= COUNT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ROT_ROW0:    rot_ff[0] <= csr_wdata[47:0];
            CSR_ROT_ROW1:    rot_ff[1] <= csr_wdata[47:0];
            CSR_ROT_ROW2:    rot_ff[2] <= csr_wdata[47:0];
            CSR_TRANSLATION: trans_ff  <= csr_wdata;
            CSR_POINT_COUNT: count_ff  <= csr_wdata[10:0];
            default: begin
            end
         endcase
      end
   end

   // query point and transform
   logic signed [19:0] p_ff [3];
   logic signed [19:0] q_ff [3];
   logic signed [35:0] prod_ff;
   logic signed [35:0] prod_in;
   logic               prod_vld_ff;
   logic [1:0]         prod_row_ff, prod_col_ff;
   logic signed [37:0] acc_ff, acc_in;
   logic               acc_done_ff;
   logic [1:0]         acc_row_ff;
   logic signed [15:0] r_sel;
   logic signed [19:0] p_sel, t_sel;
   logic signed [38:0] acc_rnd;
   logic signed [24:0] rnd;
   logic signed [25:0] moved;

   always_comb begin
      r_sel   = rot_ff[cmd.mul_row][16*cmd.mul_col +: 16];
      p_sel   = p_ff[cmd.mul_col];
      prod_in = r_sel * p_sel;
      acc_in  = (prod_col_ff == 2'd0) ? 38'(prod_ff) : acc_ff + 38'(prod_ff);
      t_sel   = trans_ff[20*acc_row_ff +: 20];
      acc_rnd = 39'(acc_ff) + 39'sd8192;
      rnd     = acc_rnd[38:14];
      moved   = 26'(rnd) + 26'(t_sel);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         p_ff[0] <= req_data.point_x;
         p_ff[1] <= req_data.point_y;
         p_ff[2] <= req_data.point_z;
      end
      if (cmd.mul_issue) begin
         prod_ff     <= prod_in;
         prod_row_ff <= cmd.mul_row;
         prod_col_ff <= cmd.mul_col;
      end
      if (prod_vld_ff) begin
         acc_ff     <= acc_in;
         acc_row_ff <= prod_row_ff;
      end
      if (acc_done_ff) begin
         q_ff[acc_row_ff] <= sat20(moved);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         acc_done_ff <= 1'b0;
      end else begin
         prod_vld_ff <= cmd.mul_issue;
         acc_done_ff <= prod_vld_ff && (prod_col_ff == 2'd2);
      end
   end

   // point store
   logic [59:0]    mem [MAX_POINTS];
   logic [59:0]    mem_q_ff;
   logic [AW-1:0]  rd_addr_ff;
   logic [AW-1:0]  last_idx;
   logic [LW-1:0]  cnt_w;
   logic [SW-1:0]  slot_w;
   logic           slot_ok;

   always_comb begin
      cnt_w   = LW'(count_ff);
      slot_w  = SW'(req_data.slot);
      slot_ok = 32'(req_data.slot) < 32'(MAX_POINTS);
      if (cnt_w == '0) begin
         last_idx = '0;
      end else if (cnt_w > LW'(MAX_POINTS)) begin
         last_idx = AW'(MAX_POINTS - 1);
      end else begin
         last_idx = AW'(cnt_w - LW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_we && slot_ok) begin
         mem[slot_w[AW-1:0]] <= {req_data.point_z, req_data.point_y, req_data.point_x};
      end
      if (cmd.scan_issue) begin
         mem_q_ff <= mem[rd_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_addr_ff <= '0;
      end else if (cmd.scan_issue) begin
         rd_addr_ff <= rd_addr_ff + AW'(1);
      end
   end

   // distance pipeline
   logic               s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;
   logic [AW-1:0]      s1_idx_ff, s2_idx_ff, s3_idx_ff, s4_idx_ff;
   logic [59:0]        s2_pt_ff, s3_pt_ff, s4_pt_ff;
   logic signed [20:0] d_ff [3];
   logic [39:0]        sq_ff [3];
   logic [41:0]        sum_ff;
   logic signed [41:0] sq_in [3];
   logic signed [19:0] e_x, e_y, e_z;

   always_comb begin
      e_x = mem_q_ff[19:0];
      e_y = mem_q_ff[39:20];
      e_z = mem_q_ff[59:40];
      for (int k = 0; k < 3; k++) begin
         sq_in[k] = d_ff[k] * d_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff <= rd_addr_ff;
      d_ff[0]   <= 21'(e_x) - 21'(q_ff[0]);
      d_ff[1]   <= 21'(e_y) - 21'(q_ff[1]);
      d_ff[2]   <= 21'(e_z) - 21'(q_ff[2]);
      s2_pt_ff  <= mem_q_ff;
      s2_idx_ff <= s1_idx_ff;
      for (int k = 0; k < 3; k++) begin
         sq_ff[k] <= sq_in[k][39:0];
      end
      s3_pt_ff  <= s2_pt_ff;
      s3_idx_ff <= s2_idx_ff;
      sum_ff    <= 42'(sq_ff[0]) + 42'(sq_ff[1]) + 42'(sq_ff[2]);
      s4_pt_ff  <= s3_pt_ff;
      s4_idx_ff <= s3_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= cmd.scan_issue;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
      end
   end

   // running best; the scan always starts at entry zero
   logic [41:0]   best_d_ff;
   logic [AW-1:0] best_idx_ff;
   logic [59:0]   best_pt_ff;
   logic [SW-1:0] best_idx_w;

   always_ff @(posedge clock) begin
      if (s4_vld_ff && (s4_idx_ff == '0 || sum_ff < best_d_ff)) begin
         best_d_ff   <= sum_ff;
         best_idx_ff <= s4_idx_ff;
         best_pt_ff  <= s4_pt_ff;
      end
   end

   // result register
   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   assign best_idx_w = SW'(best_idx_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff.match_index  <= best_idx_w[9:0];
         rsp_ff.match_x      <= best_pt_ff[19:0];
         rsp_ff.match_y      <= best_pt_ff[39:20];
         rsp_ff.match_z      <= best_pt_ff[59:40];
         rsp_ff.min_distance <= 46'(best_d_ff);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_ff;
   assign sts.scan_last = (rd_addr_ff == last_idx);
   assign sts.out_busy  = rsp_valid_ff && rsp_stall;

endmodule

// File: sv/rigid_transform_closest_point.sv
// Top level of the rigid-transform closest-point search.
// Request beats carry an action: a load writes the point into store entry
// slot (slots at or above MAX_POINTS are dropped) and gives no response; a
// query rotates and translates the point by the csr registers and scans the
// first point_count store entries (0 counts as 1, large values clip to
// MAX_POINTS) for the nearest one, lowest index on ties.
// After a query is taken req_stall stays high for the transform (one
// multiply per cycle), the scan (one store read per cycle), the drain of
// the distance pipeline and the hand-over to the output register. The
// response is valid in the next cycle, when the next request can be
// taken. The block takes no new request until it is through with a query.
// The response sits in an output register: the next request is taken while
// it waits, and a query that finishes meanwhile waits in the block until
// rsp_stall drops. Reset clears control and csr registers (identity
// rotation, zero translation, count 1); store contents stay undefined
// until loaded. The user must let csr writes go in only while the block
// is idle; the block itself does not enforce it.
module rigid_transform_closest_point #(
   parameter int MAX_POINTS = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rtcp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rtcp_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [59:0]       csr_wdata
);
   import rtcp_pkg::*;

   cmd_type cmd;
   sts_type sts;

   rtcp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_data.action),
      .req_stall  (req_stall),
      .cmd        (cmd),
      .sts        (sts)
   );

   rtcp_dp #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: tb/sv/rigid_transform_closest_point_tb.sv
// Self-checking testbench for the rigid-transform closest-point search.
module rigid_transform_closest_point_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rtcp_pkg::*;

   localparam int MAX_POINTS = 1024;
   localparam int FILL_SLOTS = 256;
   localparam int PHASE_BEATS = 36;
   localparam int QUIET_LIMIT = 8000;
   localparam int SETTLE_CYCLES = 32;
   localparam int HOLD_CYCLES = 400;
   localparam longint COORD_MAX = 524287;
   localparam longint COORD_MIN = -524288;
   localparam logic signed [19:0] Q_MAX = 20'h7FFFF;
   localparam logic signed [19:0] Q_MIN = 20'h80000;
   localparam logic signed [19:0] C_ZERO = 20'h00000;
   localparam logic [45:0] DIST_FULL = 46'd3298528591875;
   localparam logic [45:0] DIST_HALF = 46'd824630575107;
   localparam rsp_type NO_MATCH = '0;

   typedef enum logic {ROW_BEAT, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [2:0]   csr_index;
      logic [59:0]  csr_value;
      req_type      beat;
      logic         pinned;
      rsp_type      want;
   } drill_row_type;

   localparam drill_row_type DRILL [20] = '{
      '{ROW_BEAT, '0, '0, '{ACT_LOAD, 10'd0, C_ZERO, C_ZERO, C_ZERO}, 1'b0, NO_MATCH},
      '{ROW_BEAT, '0, '0, '{ACT_QUERY, 10'd0, C_ZERO, C_ZERO, C_ZERO},
        1'b1, '{10'd0, C_ZERO, C_ZERO, C_ZERO, 46'd0}},
      '{ROW_BEAT, '0, '0, '{ACT_LOAD, 10'd0, Q_MAX, Q_MAX, Q_MAX}, 1'b0, NO_MATCH},
      '{ROW_BEAT, '0, '0, '{ACT_QUERY, 10'd0, Q_MIN, Q_MIN, Q_MIN},
        1'b1, '{10'd0, Q_MAX, Q_MAX, Q_MAX, DIST_FULL}},
      '{ROW_BEAT, '0, '0, '{ACT_LOAD, 10'd1, Q_MAX, Q_MAX, Q_MAX}, 1'b0, NO_MATCH},
      '{ROW_CSR, CSR_POINT_COUNT, 60'd2, '0, 1'b0, NO_MATCH},
      // equal distances: lowest index wins
      '{ROW_BEAT, '0, '0, '{ACT_QUERY, 10'd0, C_ZERO, C_ZERO, C_ZERO},
        1'b1, '{10'd0, Q_MAX, Q_MAX, Q_MAX, DIST_HALF}},
      '{ROW_BEAT, '0, '0, '{ACT_LOAD, 10'd2, Q_MIN, Q_MIN, Q_MIN}, 1'b0, NO_MATCH},
      // count zero scans entry 0 only
      '{ROW_CSR, CSR_POINT_COUNT, 60'd0, '0, 1'b0, NO_MATCH},
      '{ROW_BEAT, '0, '0, '{ACT_QUERY, 10'd5, Q_MIN, Q_MIN, Q_MIN},
        1'b1, '{10'd0, Q_MAX, Q_MAX, Q_MAX, DIST_FULL}},
      '{ROW_CSR, CSR_POINT_COUNT, 60'd3, '0, 1'b0, NO_MATCH},
      '{ROW_BEAT, '0, '0, '{ACT_QUERY, 10'h3FF, Q_MIN, Q_MIN, Q_MIN},
        1'b1, '{10'd2, Q_MIN, Q_MIN, Q_MIN, 46'd0}},
      '{ROW_BEAT, '0, '0, '{ACT_LOAD, 10'h3FF, 20'sd1, -20'sd1, 20'sd1000}, 1'b0, NO_MATCH},
      '{ROW_CSR, CSR_TRANSLATION, {C_ZERO, Q_MIN, Q_MAX}, '0, 1'b0, NO_MATCH},
      '{ROW_BEAT, '0, '0, '{ACT_QUERY, 10'd0, Q_MAX, Q_MAX, Q_MAX}, 1'b0, NO_MATCH},
      '{ROW_CSR, CSR_ROT_ROW0, 60'h000_FFFF_FFFF_FFFF, '0, 1'b0, NO_MATCH},
      '{ROW_CSR, CSR_ROT_ROW1, 60'h000_7FFF_8000_7FFF, '0, 1'b0, NO_MATCH},
      '{ROW_CSR, CSR_ROT_ROW2, 60'h000_8000_8000_8000, '0, 1'b0, NO_MATCH},
      '{ROW_BEAT, '0, '0, '{ACT_QUERY, 10'd0, Q_MAX, Q_MIN, Q_MAX}, 1'b0, NO_MATCH},
      '{ROW_BEAT, '0, '0, '{ACT_QUERY, 10'd0, Q_MIN, Q_MIN, Q_MIN}, 1'b0, NO_MATCH}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [59:0] csr_wdata = '0;

   // shadow of the block's registers and store
   logic [47:0] rot_rows [3] = '{ROT_ROW0_RESET, ROT_ROW1_RESET, ROT_ROW2_RESET};
   logic [59:0] translation = '0;
   logic [10:0] point_count = COUNT_RESET;
   logic [59:0] ref_pts [MAX_POINTS] = '{default: '0};
   bit          loaded [MAX_POINTS];
   int unsigned filled = 0;

   rsp_type     pending_matches [$];
   logic        pin_valid = 1'b0;
   rsp_type     pin_want = '0;
   int          mismatches = 0;
   int          idle_pct = 0;
   int          stall_pct = 0;
   int          hold_ask = 0;
   int          hold_left = 0;

   rigid_transform_closest_point #(.MAX_POINTS(MAX_POINTS)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned scan_span();
      if (point_count == 11'd0) return 1;
      if (point_count > 11'd1024) return MAX_POINTS;
      return int'(point_count);
   endfunction

   function automatic rsp_type nearest_point(input req_type q);
      logic signed [19:0] in_pt [3];
      longint moved [3];
      longint acc, diff, d, best_d;
      int unsigned best_j;
      logic [59:0] e;
      rsp_type r;
      in_pt[0] = q.point_x;
      in_pt[1] = q.point_y;
      in_pt[2] = q.point_z;
      for (int row = 0; row < 3; row++) begin
         acc = 0;
         for (int col = 0; col < 3; col++) begin
            acc += longint'($signed(rot_rows[row][16*col +: 16])) * longint'(in_pt[col]);
         end
         acc = ((acc + 64'sd8192) >>> 14) + longint'($signed(translation[20*row +: 20]));
         moved[row] = acc > COORD_MAX ? COORD_MAX : (acc < COORD_MIN ? COORD_MIN : acc);
      end
      best_d = 0;
      best_j = 0;
      for (int unsigned j = 0; j < scan_span(); j++) begin
         e = ref_pts[j];
         d = 0;
         for (int c = 0; c < 3; c++) begin
            diff = longint'($signed(e[20*c +: 20])) - moved[c];
            d += diff * diff;
         end
         if (j == 0 || d < best_d) begin
            best_d = d;
            best_j = j;
         end
      end
      e = ref_pts[best_j];
      r.match_index = best_j[9:0];
      r.match_x = e[19:0];
      r.match_y = e[39:20];
      r.match_z = e[59:40];
      r.min_distance = best_d[45:0];
      return r;
   endfunction

   function automatic logic signed [19:0] rand_coord();
      case ($urandom_range(9))
         0: return Q_MAX;
         1: return Q_MIN;
         2: return C_ZERO;
         3, 4: return 20'(int'($urandom_range(4095)) - 2048);
         default: return 20'($urandom);
      endcase
   endfunction

   // loads cluster in the scanned range; queries mostly land near stored points
   function automatic req_type next_beat(input int query_pct);
      req_type b;
      int unsigned span, j, mode;
      logic [59:0] e;
      logic signed [19:0] pt [3];
      longint v;
      span = scan_span();
      j = $urandom_range(span - 1);
      e = ref_pts[j];
      mode = $urandom_range(4);
      b.slot = ($urandom_range(9) < 7) ? 10'(j) : 10'($urandom);
      b.action = ($urandom_range(99) < query_pct && span <= filled) ? ACT_QUERY : ACT_LOAD;
      for (int c = 0; c < 3; c++) begin
         if (mode == 2) begin
            pt[c] = e[20*c +: 20];
         end else if (b.action == ACT_QUERY && mode < 2) begin
            v = longint'($signed(e[20*c +: 20])) + longint'(int'($urandom_range(64)) - 32);
            if (v > COORD_MAX) v = COORD_MAX;
            else if (v < COORD_MIN) v = COORD_MIN;
            pt[c] = v[19:0];
         end else begin
            pt[c] = rand_coord();
         end
      end
      b.point_x = pt[0];
      b.point_y = pt[1];
      b.point_z = pt[2];
      return b;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatches++;
      $display("%0t rtcp check failed: %s got %0h want %0h", $time, what, got, want);
   endtask

   // called on a falling edge, returns on a falling edge
   task automatic send_beat(input req_type beat);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_matches.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [2:0] index, input logic [59:0] value);
      settle();
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         CSR_ROT_ROW0, CSR_ROT_ROW1, CSR_ROT_ROW2: rot_rows[index] = value[47:0];
         CSR_TRANSLATION: translation = value;
         CSR_POINT_COUNT: point_count = value[10:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // 0 identity, 1 signed axis permutation, 2 small angle, 3 extreme entries
   task automatic set_rotation(input int style);
      logic [15:0] entry;
      logic [47:0] row;
      int unsigned shift;
      shift = $urandom_range(2);
      for (int r = 0; r < 3; r++) begin
         row = '0;
         for (int c = 0; c < 3; c++) begin
            case (style)
               0: entry = (c == r) ? 16'h4000 : 16'h0000;
               1: entry = (c == (r + shift) % 3) ?
                          ($urandom_range(1) ? 16'h4000 : 16'hC000) : 16'h0000;
               2: entry = (c == r) ? 16'(16384 - int'($urandom_range(600))) :
                          16'(int'($urandom_range(3000)) - 1500);
               default: begin
                  case ($urandom_range(4))
                     0: entry = 16'h7FFF;
                     1: entry = 16'h8000;
                     2: entry = 16'hFFFF;
                     3: entry = 16'h0000;
                     default: entry = 16'($urandom);
                  endcase
               end
            endcase
            row[16*c +: 16] = entry;
         end
         write_csr(3'(CSR_ROT_ROW0 + r), {12'd0, row});
      end
   endtask

   always @(negedge clock) begin
      if (hold_ask != 0) begin
         hold_left = hold_ask;
         hold_ask = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            if (req_data.action == ACT_LOAD) begin
               ref_pts[req_data.slot] = {req_data.point_z, req_data.point_y, req_data.point_x};
               loaded[req_data.slot] = 1'b1;
               while (filled < MAX_POINTS && loaded[filled]) filled++;
            end else begin
               pending_matches.push_back(pin_valid ? pin_want : nearest_point(req_data));
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_matches.size() == 0) begin
               report_mismatch("beat with nothing pending", 64'(rsp_data.match_index), '0);
            end else begin
               want = pending_matches.pop_front();
               if (rsp_data.match_index !== want.match_index)
                  report_mismatch("match_index", rsp_data.match_index, want.match_index);
               if (rsp_data.match_x !== want.match_x)
                  report_mismatch("match_x", rsp_data.match_x, want.match_x);
               if (rsp_data.match_y !== want.match_y)
                  report_mismatch("match_y", rsp_data.match_y, want.match_y);
               if (rsp_data.match_z !== want.match_z)
                  report_mismatch("match_z", rsp_data.match_z, want.match_z);
               if (rsp_data.min_distance !== want.min_distance)
                  report_mismatch("min_distance", rsp_data.min_distance, want.min_distance);
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("rigid_transform_closest_point: mismatch");
      $finish;
   end

   initial begin : stimulus
      req_type beat;
      int unsigned count;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DRILL[i]) begin
         if (DRILL[i].kind == ROW_CSR) begin
            write_csr(DRILL[i].csr_index, DRILL[i].csr_value);
         end else begin
            pin_valid = DRILL[i].pinned;
            pin_want = DRILL[i].want;
            send_beat(DRILL[i].beat);
         end
      end
      pin_valid = 1'b0;

      // fill the low part of the store in slot order, with a few queries mixed in
      idle_pct = 32;
      stall_pct = 32;
      set_rotation(0);
      write_csr(CSR_TRANSLATION, 60'd0);
      write_csr(CSR_POINT_COUNT, 60'd16);
      while (filled < FILL_SLOTS) begin
         beat = next_beat(5);
         if (beat.action == ACT_LOAD) beat.slot = filled[9:0];
         send_beat(beat);
      end

      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 49; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 49; end
            default: begin idle_pct = 32; stall_pct = 32; end
         endcase
         set_rotation(ph % 4);
         write_csr(CSR_TRANSLATION,
                   ph == 0 ? 60'd0 : {rand_coord(), rand_coord(), rand_coord()});
         case (ph)
            1: count = FILL_SLOTS;
            5: count = 0;
            6: count = 1;
            7: count = FILL_SLOTS - 1;
            default: count = $urandom_range(40, 2);
         endcase
         write_csr(CSR_POINT_COUNT, 60'(count));
         // long receiver hold-off while the sender keeps offering queries
         if (ph == 4) hold_ask = HOLD_CYCLES;
         for (int k = 0; k < PHASE_BEATS; k++) begin
            send_beat(next_beat(ph == 4 ? 70 : (scan_span() > 128 ? 15 : 45)));
         end
      end

      settle();
      if (mismatches == 0 && pending_matches.size() == 0) begin
         $display("rigid_transform_closest_point: match");
      end else begin
         $display("rigid_transform_closest_point: mismatch");
      end
      $finish;
   end

endmodule

// File: rigid_transform_closest_point.f
+incdir+sv
sv/rtcp_pkg.sv
sv/rtcp_ctrl.sv
sv/rtcp_dp.sv
sv/rigid_transform_closest_point.sv
tb/sv/rigid_transform_closest_point_tb.sv
